// File: src/rpv_pkg.sv
// rpv_pkg: shared types, constants and byte class function for the path validator
// no dependencies; imported by every module under src

package rpv_pkg;

    // field and state widths
    localparam int CH_W      = 8;
    localparam int TOTAL_W   = 12;
    localparam int SEG_W     = 9;
    localparam int COUNT_W   = 9;
    localparam int PLIM_W    = 12;
    localparam int SLIM_W    = 8;
    localparam int DLIM_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    // saturation points of the counters
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [SEG_W-1:0]   SEG_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_OK      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT   = 2'd3;

    // register reset values
    localparam logic              RST_EMPTY_OK      = 1'b0;
    localparam logic [PLIM_W-1:0] RST_PATH_LIMIT    = 12'd256;
    localparam logic [SLIM_W-1:0] RST_SEGMENT_LIMIT = 8'd64;
    localparam logic [DLIM_W-1:0] RST_DEPTH_LIMIT   = 8'd8;

    // special bytes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;

    // configuration as seen by the checker
    typedef struct packed {
        logic              empty_ok;
        logic [PLIM_W-1:0] path_limit;
        logic [SLIM_W-1:0] segment_limit;
        logic [DLIM_W-1:0] depth_limit;
    } cfg_t;

    // one finished path
    typedef struct packed {
        logic valid;
        logic safe;
    } result_t;

    // letters, digits, dot, underscore, hyphen and slash
    function automatic logic byte_allowed(input logic [CH_W-1:0] c);
        logic lower, upper, digit;
        lower = (c >= 8'h61) && (c <= 8'h7A);
        upper = (c >= 8'h41) && (c <= 8'h5A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        return lower || upper || digit || (c == CH_DOT) || (c == CH_UNDER) ||
               (c == CH_DASH) || (c == CH_SLASH);
    endfunction

endpackage

// File: src/rpv_cfg_regs.sv
// rpv_cfg_regs: configuration registers behind the plain write port
// depends on rpv_pkg

module rpv_cfg_regs import rpv_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_EMPTY_OK:      cfg_next.empty_ok      = cfg_wdata[0];
                REG_PATH_LIMIT:    cfg_next.path_limit    = cfg_wdata[PLIM_W-1:0];
                REG_SEGMENT_LIMIT: cfg_next.segment_limit = cfg_wdata[SLIM_W-1:0];
                REG_DEPTH_LIMIT:   cfg_next.depth_limit   = cfg_wdata[DLIM_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.empty_ok      <= RST_EMPTY_OK;
            cfg_reg.path_limit    <= RST_PATH_LIMIT;
            cfg_reg.segment_limit <= RST_SEGMENT_LIMIT;
            cfg_reg.depth_limit   <= RST_DEPTH_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/rpv_in_stage.sv
// rpv_in_stage: input register for one path byte
// depends on rpv_pkg

module rpv_in_stage import rpv_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [CH_W-1:0] s_tdata,
    input  logic            advance,
    output logic            ch_valid,
    output logic [CH_W-1:0] ch
);

    logic            valid_reg;
    logic            valid_next;
    logic [CH_W-1:0] ch_reg;

    // take a new request when empty or when the held byte moves on
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
    end

    assign ch_valid = valid_reg;
    assign ch       = ch_reg;

endmodule

// File: src/rpv_path_check.sv
// rpv_path_check: path state and the per-byte update of counters and fail flag
// depends on rpv_pkg

module rpv_path_check import rpv_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  cfg_t            cfg,
    input  logic            ch_valid,
    input  logic [CH_W-1:0] ch,
    input  logic            out_free,
    output logic            advance,
    output result_t         res
);

    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [SEG_W-1:0]   seg_len_reg, seg_len_next;
    logic               seg_dot_reg, seg_dot_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               failed_reg, failed_next;

    logic               is_end;
    logic               is_slash;
    logic [COUNT_W-1:0] count_inc;
    logic               close_fail;
    logic               end_fail;

    assign is_end   = (ch == CH_NUL);
    assign is_slash = (ch == CH_SLASH);

    // a terminator needs room in the output register, other bytes never wait
    assign advance = ch_valid && (!is_end || out_free);

    // closing the current segment
    assign count_inc  = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign close_fail = (seg_len_reg == '0) ||
                        (seg_len_reg > {1'b0, cfg.segment_limit}) ||
                        seg_dot_reg ||
                        (count_inc > {1'b0, cfg.depth_limit});

    // path end verdict
    assign end_fail = failed_reg || (total_reg >= cfg.path_limit) || close_fail;

    always_comb begin
        total_next   = total_reg;
        seg_len_next = seg_len_reg;
        seg_dot_next = seg_dot_reg;
        count_next   = count_reg;
        failed_next  = failed_reg;
        res.valid    = 1'b0;
        res.safe     = 1'b0;
        if (advance) begin
            if (is_end) begin
                res.valid    = 1'b1;
                res.safe     = (total_reg == '0) ? cfg.empty_ok : !end_fail;
                total_next   = '0;
                seg_len_next = '0;
                seg_dot_next = 1'b0;
                count_next   = '0;
                failed_next  = 1'b0;
            end else begin
                total_next = (total_reg < TOTAL_MAX) ? total_reg + 1'b1 : total_reg;
                if (!byte_allowed(ch)) begin
                    failed_next = 1'b1;
                end
                if (is_slash) begin
                    if (close_fail) begin
                        failed_next = 1'b1;
                    end
                    count_next   = count_inc;
                    seg_len_next = '0;
                    seg_dot_next = 1'b0;
                end else begin
                    if (seg_len_reg == '0) begin
                        seg_dot_next = (ch == CH_DOT);
                    end
                    seg_len_next = (seg_len_reg < SEG_MAX) ? seg_len_reg + 1'b1
                                                           : seg_len_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            seg_len_reg <= '0;
            seg_dot_reg <= 1'b0;
            count_reg   <= '0;
            failed_reg  <= 1'b0;
        end else begin
            total_reg   <= total_next;
            seg_len_reg <= seg_len_next;
            seg_dot_reg <= seg_dot_next;
            count_reg   <= count_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

// File: src/rpv_out_stage.sv
// rpv_out_stage: result register on the master side
// depends on rpv_pkg

module rpv_out_stage import rpv_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  result_t         res,
    output logic            out_free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [CH_W-1:0] m_tdata
);

    logic valid_reg;
    logic valid_next;
    logic safe_reg;

    // free when empty or when the held result is taken this cycle
    assign out_free   = !valid_reg || m_tready;
    assign valid_next = res.valid || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (res.valid) begin
            safe_reg <= res.safe;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(CH_W-1){1'b0}}, safe_reg};

endmodule

// File: src/relative_path_validator.sv
// relative_path_validator: top level of the byte-stream path checker
// depends on rpv_pkg, rpv_cfg_regs, rpv_in_stage, rpv_path_check, rpv_out_stage
//
//   channel   dir  payload                              when
//   s_        in   s_tdata[7:0] = ch                    one request per path byte
//   m_        out  m_tdata[0] = safe, [7:1] zero        one request per zero byte
//   cfg_      in   cfg_index selects, cfg_wdata data    write when cfg_we is high
//
// One byte per cycle while no zero byte waits; an accepted byte is checked from the
// input register in the next cycle, and a zero byte's verdict goes from there into
// the output register, which drives m_tvalid.
// A zero byte waits in the input register only while the output register is
// full and not being taken; other bytes never wait.
// Synchronous active-low reset clears the path state and loads register defaults.

module relative_path_validator import rpv_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CH_W-1:0]      s_tdata,   // [7:0] ch
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CH_W-1:0]      m_tdata,   // [0] safe, [7:1] zero
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t            cfg;
    logic            advance;
    logic            ch_valid;
    logic [CH_W-1:0] ch;
    logic            out_free;
    result_t         res;

    rpv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rpv_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .ch_valid (ch_valid),
        .ch       (ch)
    );

    rpv_path_check u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .ch_valid (ch_valid),
        .ch       (ch),
        .out_free (out_free),
        .advance  (advance),
        .res      (res)
    );

    rpv_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: tb/tb.sv
// tb: self-checking bench for relative_path_validator, byte stream in, verdict stream out
// depends on rpv_pkg and the relative_path_validator rtl; predicts each verdict in a small class

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpv_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int CFG_SETTLE  = 4;
    localparam int TAIL_CYCLES = 10;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TIMEOUT_NS  = 2_000_000;

    // path state tracker and verdict store
    class path_verdict_board;
        cfg_t               cfg;
        logic [TOTAL_W-1:0] total_bytes;
        logic [SEG_W-1:0]   seg_bytes;
        logic               seg_dot_first;
        logic [COUNT_W-1:0] seg_closed;
        logic               path_bad;
        logic               verdicts_due[$];
        int                 mismatches;
        int                 verdicts_seen;
        int                 safe_seen;

        function new();
            cfg.empty_ok      = RST_EMPTY_OK;
            cfg.path_limit    = RST_PATH_LIMIT;
            cfg.segment_limit = RST_SEGMENT_LIMIT;
            cfg.depth_limit   = RST_DEPTH_LIMIT;
            mismatches = 0;
            verdicts_seen = 0;
            safe_seen = 0;
            clear_path();
        endfunction

        function void clear_path();
            total_bytes   = '0;
            seg_bytes     = '0;
            seg_dot_first = 1'b0;
            seg_closed    = '0;
            path_bad      = 1'b0;
        endfunction

        // each register keeps only its own width
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_EMPTY_OK:      cfg.empty_ok      = value[0];
                REG_PATH_LIMIT:    cfg.path_limit    = value[PLIM_W-1:0];
                REG_SEGMENT_LIMIT: cfg.segment_limit = value[SLIM_W-1:0];
                REG_DEPTH_LIMIT:   cfg.depth_limit   = value[DLIM_W-1:0];
                default: ;
            endcase
        endfunction

        function bit is_path_char(logic [CH_W-1:0] c);
            return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                              CH_DOT, CH_UNDER, CH_DASH, CH_SLASH});
        endfunction

        // close the running segment and count it
        function void end_segment();
            if (seg_bytes == 0 || seg_bytes > cfg.segment_limit || seg_dot_first)
                path_bad = 1'b1;
            if (seg_closed != COUNT_MAX)
                seg_closed++;
            if (seg_closed > cfg.depth_limit)
                path_bad = 1'b1;
            seg_bytes     = '0;
            seg_dot_first = 1'b0;
        endfunction

        // one accepted request; a zero byte queues a verdict
        function void predict_byte(logic [CH_W-1:0] c);
            if (c != CH_NUL) begin
                if (total_bytes != TOTAL_MAX)
                    total_bytes++;
                if (!is_path_char(c))
                    path_bad = 1'b1;
                if (c == CH_SLASH) begin
                    end_segment();
                end else begin
                    if (seg_bytes == 0)
                        seg_dot_first = (c == CH_DOT);
                    if (seg_bytes != SEG_MAX)
                        seg_bytes++;
                end
            end else begin
                if (total_bytes == 0) begin
                    verdicts_due.push_back(cfg.empty_ok);
                end else begin
                    if (total_bytes >= cfg.path_limit)
                        path_bad = 1'b1;
                    end_segment();
                    verdicts_due.push_back(!path_bad);
                end
                clear_path();
            end
        endfunction

        // compare one verdict with the oldest prediction
        function void check_verdict(logic [CH_W-1:0] data);
            logic want;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                $display("%0t: verdict %0d arrived with no path pending", $time, data[0]);
                return;
            end
            want = verdicts_due.pop_front();
            verdicts_seen++;
            if (data[0])
                safe_seen++;
            if (data[0] !== want) begin
                mismatches++;
                $display("%0t: safe mismatch, expected %0d, actual %0d", $time, want, data[0]);
            end
            if (data[CH_W-1:1] !== '0) begin
                mismatches++;
                $display("%0t: padding mismatch, expected 0, actual %0h",
                         $time, data[CH_W-1:1]);
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void note_leftover();
            if (verdicts_due.size() != 0) begin
                mismatches += verdicts_due.size();
                $display("%0t: %0d expected verdicts never arrived", $time,
                         verdicts_due.size());
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CH_W-1:0]      s_tdata;   // [7:0] ch
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CH_W-1:0]      m_tdata;   // [0] safe, [7:1] zero
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    path_verdict_board sb = new();

    logic hold_req;
    int   rx_mode;
    bit   gaps_on;
    int   burst_left;
    int   bytes_sent;
    int   paths_sent;
    int   settings_used;

    relative_path_validator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: stall pattern per phase, plus a long hold when asked
    initial begin : rx_side
        int hold_left;
        int tick;
        m_tready = 1'b0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // verdict monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                sb.check_verdict(m_tdata);
        end
    end

    // sender bursts, with random gaps between them when gaps are on
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // offer one byte and wait for the request to be taken
    task automatic send_byte(input logic [CH_W-1:0] c);
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.predict_byte(c);
        bytes_sent++;
        if (c == CH_NUL)
            paths_sent++;
        @(negedge aclk);
        pace();
    endtask

    task automatic send_path(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
        send_byte(CH_NUL);
    endtask

    function automatic logic [CH_W-1:0] rand_name_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 61 : 64);
        if (r < 26)
            return 8'h61 + 8'(r);
        else if (r < 52)
            return 8'h41 + 8'(r - 26);
        else if (r < 62)
            return 8'h30 + 8'(r - 52);
        else if (r == 62)
            return CH_DOT;
        else if (r == 63)
            return CH_UNDER;
        return CH_DASH;
    endfunction

    function automatic logic [CH_W-1:0] rand_bad_char();
        logic [CH_W-1:0] c;
        do c = 8'($urandom_range(1, 255)); while (sb.is_path_char(c));
        return c;
    endfunction

    // regular segments of seg_len letters and digits split by slashes
    task automatic send_long(input int total, input int seg_len);
        for (int i = 0; i < total; i++)
            send_byte(((i + 1) % (seg_len + 1) == 0) ? CH_SLASH : rand_name_char(1'b1));
        send_byte(CH_NUL);
    endtask

    // mostly well formed paths sized to the current limits, some broken, some noise
    task automatic send_random_path();
        logic [CH_W-1:0] text[$];
        int kind;
        int nseg;
        int seglen;
        int maxseg;
        int maxlen;
        int pos;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(1, 255)));
        end else if (kind >= 15) begin
            maxseg = (sb.cfg.depth_limit == 0) ? 1 :
                     (sb.cfg.depth_limit > 6) ? 6 : int'(sb.cfg.depth_limit);
            maxlen = (sb.cfg.segment_limit == 0) ? 1 :
                     (sb.cfg.segment_limit > 8) ? 8 : int'(sb.cfg.segment_limit);
            nseg = $urandom_range(1, maxseg) + (($urandom_range(0, 9) == 0) ? 1 : 0);
            for (int s = 0; s < nseg; s++) begin
                if (s > 0)
                    text.push_back(CH_SLASH);
                seglen = $urandom_range(1, maxlen) + (($urandom_range(0, 9) == 0) ? 1 : 0);
                for (int k = 0; k < seglen; k++)
                    text.push_back(rand_name_char(k == 0));
            end
            // break about one path in four
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(0, text.size() - 1);
                case ($urandom_range(0, 4))
                    0: text.push_front(CH_SLASH);
                    1: text.push_back(CH_SLASH);
                    2: begin
                        text.insert(pos, CH_SLASH);
                        text.insert(pos, CH_SLASH);
                    end
                    3: text[pos] = rand_bad_char();
                    default: text[0] = CH_DOT;
                endcase
            end
        end
        // the remaining kinds are empty paths
        foreach (text[i])
            send_byte(text[i]);
        send_byte(CH_NUL);
    endtask

    // let every verdict come back and the pipe go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (CFG_SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] allow, input logic [CFG_W-1:0] plim,
                                  input logic [CFG_W-1:0] slim, input logic [CFG_W-1:0] dlim);
        drain();
        write_reg(REG_EMPTY_OK, allow);
        write_reg(REG_PATH_LIMIT, plim);
        write_reg(REG_SEGMENT_LIMIT, slim);
        write_reg(REG_DEPTH_LIMIT, dlim);
        settings_used++;
    endtask

    // main sequence
    initial begin
        int start_bytes;
        int start_paths;
        int wait_cycles;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_EMPTY_OK;
        cfg_wdata  = '0;
        hold_req   = 1'b0;
        rx_mode    = 0;
        gaps_on    = 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        paths_sent = 0;
        settings_used = 1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed checks at reset limits
        gaps_on = 1'b1;
        rx_mode = 1;
        send_path("");
        send_path("z0/9Z");
        send_path("/a");
        send_path("a/");
        send_path(".a");
        send_path("a//b");
        send_path("A\\b");
        send_byte(8'hFF);
        send_byte(CH_NUL);

        // moderate limits: boundary lengths, segment size and depth
        apply_settings(12'd1, 12'd38, 12'd12, 12'd3);
        gaps_on = 1'b0;
        rx_mode = 3;
        send_path("");
        send_long(37, 12);
        send_long(38, 12);
        send_long(12, 12);
        send_long(13, 13);
        send_long(20, 6);
        send_long(27, 6);

        // tightest useful limits
        apply_settings(12'd0, 12'd2, 12'd1, 12'd1);
        gaps_on = 1'b1;
        rx_mode = 2;
        send_path("");
        send_path("a");
        send_path("ab");
        send_path("a/b");
        send_path(".");
        repeat (8) send_random_path();

        apply_settings(12'd1, 12'd1, 12'd1, 12'd1);
        send_path("");
        send_path("a");
        repeat (4) send_random_path();

        // zero limits, upper data bits dropped by the narrow registers
        apply_settings(12'hFFF, 12'h000, 12'hF00, 12'hE00);
        rx_mode = 0;
        repeat (8) send_random_path();

        // random settings
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 7)
                apply_settings(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                               12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            else
                apply_settings(12'($urandom_range(0, 1)), 12'($urandom_range(1, 64)),
                               12'($urandom_range(1, 10)), 12'($urandom_range(1, 6)));
            gaps_on = (phase % 3) != 0;
            rx_mode = phase % 4;
            if (phase == 2) begin
                // hold the receiver off while short paths pile up
                hold_req <= 1'b1;
                gaps_on = 1'b0;
                repeat (16) send_path("a");
                gaps_on = 1'b1;
            end
            start_bytes = bytes_sent;
            start_paths = paths_sent;
            while (bytes_sent - start_bytes < 40 || paths_sent - start_paths < 5)
                send_random_path();
        end

        // wind down
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
        sb.note_leftover();
        $display("covered %0d path bytes in %0d paths under %0d register settings",
                 bytes_sent, paths_sent, settings_used);
        $display("verdicts checked %0d (%0d safe, %0d rejected), mismatches %0d",
                 sb.verdicts_seen, sb.safe_seen, sb.verdicts_seen - sb.safe_seen,
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: relative_path_validator.f
src/rpv_pkg.sv
src/rpv_cfg_regs.sv
src/rpv_in_stage.sv
src/rpv_path_check.sv
src/rpv_out_stage.sv
src/relative_path_validator.sv
tb/tb.sv
